// ===== hw/rtl/vehicle_alert_qualifier_defines.svh =====
// Assertion helpers for the vehicle alert qualifier.
// Each macro samples on clk and is disabled while rst is high.
`ifndef VEHICLE_ALERT_QUALIFIER_DEFINES_SVH
`define VEHICLE_ALERT_QUALIFIER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define VAQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define VAQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vaq_pkg.sv =====
package vaq_pkg;

  localparam int CFG_BITS = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int KM_BITS = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OVERSPEED_HOLD = 3'd0,
    CFG_OVERSPEED_GAP  = 3'd1,
    CFG_TIRE_HOLD      = 3'd2,
    CFG_TIRE_GAP       = 3'd3,
    CFG_DOOR_DELAY     = 3'd4
  } vaq_cfg_idx_t;

  localparam logic [CFG_BITS-1:0] RST_OVERSPEED_HOLD = 32'd2000;
  localparam logic [CFG_BITS-1:0] RST_OVERSPEED_GAP  = 32'd60000;
  localparam logic [CFG_BITS-1:0] RST_TIRE_HOLD      = 32'd3000;
  localparam logic [CFG_BITS-1:0] RST_TIRE_GAP       = 32'd120000;
  localparam logic [CFG_BITS-1:0] RST_DOOR_DELAY     = 32'd60000;

  localparam logic [KM_BITS-1:0] SERVICE_STEP = 8'd10;

  typedef enum logic [1:0] {
    ENG_OFF     = 2'd0,
    ENG_ON      = 2'd1,
    ENG_UNKNOWN = 2'd2
  } vaq_engine_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] hold;
    logic [CFG_BITS-1:0] gap;
  } vaq_hold_cfg_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic               engine_on;
    logic [KM_BITS-1:0] speed_kmh;
    logic [KM_BITS-1:0] speed_limit_kmh;
    logic               tire_ok;
    logic               door_closed;
    logic [KM_BITS-1:0] total_km;
  } vaq_sample_t;

  typedef struct packed {
    logic               overspeed_alert;
    logic               tire_alert;
    logic               door_alert;
    logic               service_alert;
    logic [KM_BITS-1:0] service_mark_km;
  } vaq_result_t;

  // Nonzero multiple of ten: quotient by reciprocal 205/2048, exact for 8-bit values.
  function automatic logic is_service_mark(input logic [KM_BITS-1:0] km);
    logic [15:0]        prod;
    logic [4:0]         quo;
    logic [KM_BITS-1:0] back;
    prod = 16'(km) * 16'd205;
    quo  = prod[15:11];
    back = 8'({3'b000, quo} * SERVICE_STEP);
    return (km != '0) && (back == km);
  endfunction

endpackage

// ===== hw/rtl/vaq_if.sv =====
interface vaq_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic        engine_on;
  logic [7:0]  speed_kmh;
  logic [7:0]  speed_limit_kmh;
  logic        tire_ok;
  logic        door_closed;
  logic [7:0]  total_km;

  modport source (
    output valid, time_ms, engine_on, speed_kmh, speed_limit_kmh, tire_ok,
           door_closed, total_km,
    input  ready
  );
  modport sink (
    input  valid, time_ms, engine_on, speed_kmh, speed_limit_kmh, tire_ok,
           door_closed, total_km,
    output ready
  );
endinterface

interface vaq_result_if;
  logic       valid;
  logic       ready;
  logic       overspeed_alert;
  logic       tire_alert;
  logic       door_alert;
  logic       service_alert;
  logic [7:0] service_mark_km;

  modport source (
    output valid, overspeed_alert, tire_alert, door_alert, service_alert,
           service_mark_km,
    input  ready
  );
  modport sink (
    input  valid, overspeed_alert, tire_alert, door_alert, service_alert,
           service_mark_km,
    output ready
  );
endinterface

// ===== hw/rtl/vaq_hold_rule.sv =====
module vaq_hold_rule
  import vaq_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 cond,
  input  logic [TIME_BITS-1:0] t,
  input  vaq_hold_cfg_t        cfg,
  output logic                 alert
);

  localparam int CmpBits = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  logic                 holding;
  logic [TIME_BITS-1:0] start;
  logic [TIME_BITS-1:0] last_alert;
  logic [TIME_BITS-1:0] since_start;
  logic [TIME_BITS-1:0] since_alert;
  logic                 hold_met;
  logic                 gap_met;

  assign since_start = t - start;
  assign since_alert = t - last_alert;
  assign hold_met = CmpBits'(since_start) >= CmpBits'(cfg.hold);
  assign gap_met  = CmpBits'(since_alert) >= CmpBits'(cfg.gap);
  assign alert = cond && holding && hold_met && gap_met;

  always_ff @(posedge clk) begin
    if (rst) begin
      holding    <= 1'b0;
      start      <= '0;
      last_alert <= '0;
    end else if (step) begin
      holding <= cond;
      if (cond && !holding) begin
        start <= t;
      end
      if (alert) begin
        last_alert <= t;
      end
    end
  end

endmodule

// ===== hw/rtl/vaq_door_rule.sv =====
module vaq_door_rule
  import vaq_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 engine_on,
  input  logic                 door_closed,
  input  logic [TIME_BITS-1:0] t,
  input  logic [CFG_BITS-1:0]  delay,
  output logic                 alert
);

  localparam int CmpBits = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  vaq_engine_t          prior_engine;
  logic                 off_active;
  logic [TIME_BITS-1:0] off_start;
  logic                 done;
  logic                 new_off;
  logic                 active_now;
  logic                 done_now;
  logic [TIME_BITS-1:0] start_now;
  logic [TIME_BITS-1:0] since_off;

  assign new_off    = (prior_engine == ENG_ON) && !engine_on;
  assign active_now = new_off || off_active;
  assign done_now   = new_off ? 1'b0 : done;
  assign start_now  = new_off ? t : off_start;
  assign since_off  = t - start_now;
  assign alert = active_now && !done_now && !door_closed &&
                 (CmpBits'(since_off) >= CmpBits'(delay));

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_engine <= ENG_UNKNOWN;
      off_active   <= 1'b0;
      off_start    <= '0;
      done         <= 1'b0;
    end else if (step) begin
      prior_engine <= engine_on ? ENG_ON : ENG_OFF;
      off_start    <= start_now;
      if (engine_on) begin
        off_active <= 1'b0;
        done       <= 1'b0;
      end else begin
        off_active <= active_now;
        done       <= done_now || alert;
      end
    end
  end

endmodule

// ===== hw/rtl/vaq_service_rule.sv =====
module vaq_service_rule
  import vaq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [KM_BITS-1:0] total_km,
  output logic               alert,
  output logic [KM_BITS-1:0] mark_km
);

  logic [KM_BITS-1:0] last_mark;
  logic               mark_valid;

  assign alert   = is_service_mark(total_km) && (!mark_valid || (last_mark != total_km));
  assign mark_km = alert ? total_km : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mark  <= '0;
      mark_valid <= 1'b0;
    end else if (step && alert) begin
      last_mark  <= total_km;
      mark_valid <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/vehicle_alert_qualifier.sv =====
// Channel  | Dir | Handshake    | Payload
// sample   | in  | valid/ready  | time_ms, engine_on, speed, limit, tire, door, total_km
// result   | out | valid/ready  | four alert flags, service_mark_km
// cfg      | in  | cfg_we only  | cfg_index, cfg_data
//
// One transaction per cycle unless the result channel stalls; a taken sample is registered in
// the input register, then its result in the result register after the rule logic.
// Synchronous reset loads the register defaults and clears all rule state.
// A stalled result holds the input register; sample.ready drops only then.
`include "vehicle_alert_qualifier_defines.svh"

module vehicle_alert_qualifier
  import vaq_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  vaq_sample_if.sink              sample,
  vaq_result_if.source            result
);

  vaq_hold_cfg_t       overspeed_cfg;
  vaq_hold_cfg_t       tire_cfg;
  logic [CFG_BITS-1:0] door_delay;

  logic                 stage_valid;
  vaq_sample_t          stage;
  logic                 advance;
  logic [TIME_BITS-1:0] t;
  logic                 out_valid;
  vaq_result_t          out_q;
  vaq_result_t          res_next;
  logic                 overspeed_cond;
  logic                 tire_cond;
  logic                 overspeed_hit;
  logic                 tire_hit;
  logic                 door_hit;
  logic                 service_hit;
  logic [KM_BITS-1:0]   service_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      overspeed_cfg.hold <= RST_OVERSPEED_HOLD;
      overspeed_cfg.gap  <= RST_OVERSPEED_GAP;
      tire_cfg.hold      <= RST_TIRE_HOLD;
      tire_cfg.gap       <= RST_TIRE_GAP;
      door_delay         <= RST_DOOR_DELAY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OVERSPEED_HOLD: overspeed_cfg.hold <= cfg_data;
        CFG_OVERSPEED_GAP:  overspeed_cfg.gap  <= cfg_data;
        CFG_TIRE_HOLD:      tire_cfg.hold      <= cfg_data;
        CFG_TIRE_GAP:       tire_cfg.gap       <= cfg_data;
        CFG_DOOR_DELAY:     door_delay         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance      = stage_valid && (!out_valid || result.ready);
  assign sample.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample.ready) begin
      stage_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      stage.time_ms         <= sample.time_ms;
      stage.engine_on       <= sample.engine_on;
      stage.speed_kmh       <= sample.speed_kmh;
      stage.speed_limit_kmh <= sample.speed_limit_kmh;
      stage.tire_ok         <= sample.tire_ok;
      stage.door_closed     <= sample.door_closed;
      stage.total_km        <= sample.total_km;
    end
  end

  assign t = TIME_BITS'(stage.time_ms);
  assign overspeed_cond = (stage.speed_limit_kmh != '0) &&
                          (stage.speed_kmh > stage.speed_limit_kmh);
  assign tire_cond = !stage.engine_on && !stage.tire_ok;

  vaq_hold_rule #(.TIME_BITS(TIME_BITS)) u_overspeed (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .cond  (overspeed_cond),
    .t     (t),
    .cfg   (overspeed_cfg),
    .alert (overspeed_hit)
  );

  vaq_hold_rule #(.TIME_BITS(TIME_BITS)) u_tire (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .cond  (tire_cond),
    .t     (t),
    .cfg   (tire_cfg),
    .alert (tire_hit)
  );

  vaq_door_rule #(.TIME_BITS(TIME_BITS)) u_door (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .engine_on   (stage.engine_on),
    .door_closed (stage.door_closed),
    .t           (t),
    .delay       (door_delay),
    .alert       (door_hit)
  );

  vaq_service_rule u_service (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .total_km (stage.total_km),
    .alert    (service_hit),
    .mark_km  (service_mark)
  );

  assign res_next = {overspeed_hit, tire_hit, door_hit, service_hit, service_mark};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.overspeed_alert = out_q.overspeed_alert;
  assign result.tire_alert      = out_q.tire_alert;
  assign result.door_alert      = out_q.door_alert;
  assign result.service_alert   = out_q.service_alert;
  assign result.service_mark_km = out_q.service_mark_km;

  `VAQ_ASSERT_NEXT(a_advance_fills_result, advance, result.valid, "result missing after advance")
  `VAQ_ASSERT_NOW(a_stall_only_from_result, !sample.ready,
    stage_valid && result.valid && !result.ready, "input stalled without output stall")
  `VAQ_ASSERT_NOW(a_mark_only_with_alert, result.valid && !result.service_alert,
    result.service_mark_km == '0, "service mark without service alert")

endmodule
